@@ hdl/epda_pkg.sv @@
// ----------------------------------------------------------------------------
// epda_pkg
// Shared types and constants for the early packet discard admission block:
// beat layouts, drop causes, register indexes and per-channel flag storage.
// ----------------------------------------------------------------------------
package epda_pkg;

  // Physical depth of the shared cell buffer; the programmed capacity is
  // clipped to this.
  localparam int unsigned BUFFER_DEPTH = 1024;

  // Field widths fixed by the beat formats.
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned CFG_W      = 11;
  localparam int unsigned ACT_W      = 9;
  localparam int unsigned CH_IN_W    = 8;
  localparam int unsigned S_TDATA_W  = 16;
  localparam int unsigned S_TUSER_W  = 2;
  localparam int unsigned M_TDATA_W  = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  // Capacity limit expressed at counter width.
  localparam logic [CNT_W-1:0] DEPTH_LIMIT = CNT_W'(BUFFER_DEPTH);

  typedef enum logic {
    OP_ARRIVAL,
    OP_SERVE
  } opcode_t;

  typedef enum logic [1:0] {
    CAUSE_NONE,
    CAUSE_FRAME,
    CAUSE_FULL,
    CAUSE_ILLEGAL
  } drop_cause_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EARLY_THRESHOLD,
    REG_LOW_PRIORITY_THRESHOLD,
    REG_BUFFER_CAPACITY,
    REG_ACTIVE_CHANNELS
  } cfg_reg_t;

  // Per-channel frame tracking flags, both set after reset.
  typedef struct packed {
    logic frame_ok;
    logic at_frame_start;
  } chan_flags_t;

  typedef struct packed {
    opcode_t              opcode;
    logic [CH_IN_W-1:0]   channel;
    logic                 low_priority;
    logic                 end_of_frame;
    logic                 framed_cell;
  } cell_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] early_threshold;
    logic [CFG_W-1:0] low_priority_threshold;
    logic [CFG_W-1:0] buffer_capacity;
    logic [ACT_W-1:0] active_channels;
  } admit_cfg_t;

  typedef struct packed {
    logic             accepted;
    drop_cause_t      drop_cause;
    logic [CNT_W-1:0] occupancy;
  } admit_result_t;

endpackage

@@ hdl/epda_flag_ram.sv @@
// ----------------------------------------------------------------------------
// epda_flag_ram
// Per-channel flag memory with one registered read port and one write port.
// After reset it sweeps every entry to the set state, one entry per cycle.
// ----------------------------------------------------------------------------
module epda_flag_ram #(
  parameter int unsigned NUM_CHANNELS = 256,
  localparam int unsigned ADDR_W = $clog2(NUM_CHANNELS)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rd_en,
  input  logic [ADDR_W-1:0]     rd_addr,
  output epda_pkg::chan_flags_t rd_data,
  input  logic                  wr_en,
  input  logic [ADDR_W-1:0]     wr_addr,
  input  epda_pkg::chan_flags_t wr_data,
  output logic                  clearing
);
  import epda_pkg::*;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_CHANNELS - 1);

  chan_flags_t       mem [NUM_CHANNELS];
  logic [ADDR_W-1:0] clr_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  chan_flags_t       mem_wdata;

  // The clearing sweep owns the write port until it finishes.
  always_comb begin
    mem_we    = clearing | wr_en;
    mem_waddr = clearing ? clr_addr : wr_addr;
    mem_wdata = clearing ? '{frame_ok: 1'b1, at_frame_start: 1'b1} : wr_data;
  end

  // Sweep control.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  // Storage array with registered read data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

endmodule

@@ hdl/epda_decide.sv @@
// ----------------------------------------------------------------------------
// epda_decide
// Admission decision for one item: channel check, frame start thresholds,
// end-of-frame reset, overflow test and the occupancy update.
// ----------------------------------------------------------------------------
module epda_decide #(
  parameter int unsigned NUM_CHANNELS = 256
) (
  input  epda_pkg::cell_item_t          item,
  input  epda_pkg::chan_flags_t         flags,
  input  logic [epda_pkg::CNT_W-1:0]    count,
  input  epda_pkg::admit_cfg_t          cfg,
  output epda_pkg::admit_result_t       result,
  output logic [epda_pkg::CNT_W-1:0]    count_next,
  output logic                          flag_we,
  output epda_pkg::chan_flags_t         flags_next
);
  import epda_pkg::*;

  logic [CNT_W-1:0] cap;
  logic             room;
  logic             legal;
  logic             acc;
  drop_cause_t      cause;

  always_comb begin
    // Usable capacity is the programmed value clipped to the buffer depth.
    cap   = (cfg.buffer_capacity < DEPTH_LIMIT) ? cfg.buffer_capacity : DEPTH_LIMIT;
    room  = count < cap;
    legal = ({1'b0, item.channel} < cfg.active_channels) &&
            (32'(item.channel) < NUM_CHANNELS);

    flags_next = flags;
    flag_we    = 1'b0;
    count_next = count;
    acc        = 1'b0;
    cause      = CAUSE_NONE;

    if (item.opcode == OP_SERVE) begin
      // A serve removes one queued cell when there is one.
      if (count != '0) begin
        count_next = count - CNT_W'(1);
      end
    end else if (!legal) begin
      cause = CAUSE_ILLEGAL;
    end else if (!item.framed_cell) begin
      // Plain cells only see the overflow test.
      if (room) begin
        acc        = 1'b1;
        count_next = count + CNT_W'(1);
      end else begin
        cause = CAUSE_FULL;
      end
    end else begin
      flag_we = 1'b1;
      // The first cell of a frame decides the fate of the whole frame.
      if (flags.at_frame_start) begin
        flags_next.at_frame_start = 1'b0;
        if (count >= cfg.early_threshold) begin
          flags_next.frame_ok = 1'b0;
        end
        if (item.low_priority && (count >= cfg.low_priority_threshold)) begin
          flags_next.frame_ok = 1'b0;
        end
      end
      // The last cell rearms the channel and is always offered.
      if (item.end_of_frame) begin
        flags_next.frame_ok       = 1'b1;
        flags_next.at_frame_start = 1'b1;
      end
      if (!flags_next.frame_ok) begin
        cause = CAUSE_FRAME;
      end else if (room) begin
        acc        = 1'b1;
        count_next = count + CNT_W'(1);
      end else begin
        // An overflow poisons the remainder of the frame.
        flags_next.frame_ok = 1'b0;
        cause               = CAUSE_FULL;
      end
    end

    result.accepted   = acc;
    result.drop_cause = cause;
    result.occupancy  = count_next;
  end

endmodule

@@ hdl/early_packet_discard_admission.sv @@
// ----------------------------------------------------------------------------
// early_packet_discard_admission
// Admission control for a shared cell buffer using early packet discard,
// with a lower threshold for frames that start with a low-priority cell.
//
//   Channel  Direction  Handshake            Content
//   s_*      in         s_tvalid / s_tready  cell arrival or serve request
//   m_*      out        m_tvalid / m_tready  admission result per item
//   cfg_*    in         cfg_valid/cfg_ready  register index and write data
//
// One item is accepted per cycle while the output is not stalled; each result
// is loaded into the output register from the input stage (flag memory read
// at the accepting edge, then the decision into the output register).
// The per-channel flags are read and rewritten in the same flow, with a
// forwarding register covering back-to-back cells on one channel.
// After reset every entry of the flag memory is swept, during which
// s_tready stays low; configuration writes are taken throughout.
// A stalled output holds the pipeline; s_tready falls only once both the
// input stage and the output register are occupied.
// ----------------------------------------------------------------------------
module early_packet_discard_admission #(
  parameter int unsigned NUM_CHANNELS = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  // Input beats.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [epda_pkg::S_TDATA_W-1:0]    s_tdata,   // [7:0] channel, [8] low_priority
  input  logic                              s_tlast,   // end_of_frame
  input  logic [epda_pkg::S_TUSER_W-1:0]    s_tuser,   // [0] opcode, [1] framed_cell
  // Result beats.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [epda_pkg::M_TDATA_W-1:0]    m_tdata,   // [0] accepted, [2:1] drop_cause,
                                                       // [13:3] occupancy
  // Register writes.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [epda_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [epda_pkg::CFG_W-1:0]        cfg_data
);
  import epda_pkg::*;

  localparam int unsigned CH_W = $clog2(NUM_CHANNELS);

  admit_cfg_t       cfg;
  cell_item_t       in_item;
  logic [CH_W-1:0]  in_idx;
  logic             s_accept;
  logic             s1_valid;
  logic             s1_adv;
  cell_item_t       s1_item;
  logic [CH_W-1:0]  s1_idx;
  logic             lw_valid;
  logic [CH_W-1:0]  lw_idx;
  chan_flags_t      lw_flags;
  chan_flags_t      rd_flags;
  chan_flags_t      cur_flags;
  logic             clearing;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  admit_result_t    result;
  logic             flag_we;
  logic             wr_en;
  chan_flags_t      flags_next;

  // Input beat unpacking.
  always_comb begin
    in_item.opcode       = opcode_t'(s_tuser[0]);
    in_item.framed_cell  = s_tuser[1];
    in_item.channel      = s_tdata[CH_IN_W-1:0];
    in_item.low_priority = s_tdata[CH_IN_W];
    in_item.end_of_frame = s_tlast;
    in_idx               = CH_W'(s_tdata[CH_IN_W-1:0]);
  end

  // Handshake: the input stage moves on whenever the output register frees.
  assign s1_adv    = s1_valid && (!m_tvalid || m_tready);
  assign s_tready  = !clearing && (!s1_valid || s1_adv);
  assign s_accept  = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign wr_en     = s1_adv && flag_we;

  // Forward the previous cell's flags when it hit the same channel.
  assign cur_flags = (lw_valid && (lw_idx == s1_idx)) ? lw_flags : rd_flags;

  epda_flag_ram #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_flag_ram (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (s_accept),
    .rd_addr  (in_idx),
    .rd_data  (rd_flags),
    .wr_en    (wr_en),
    .wr_addr  (s1_idx),
    .wr_data  (flags_next),
    .clearing (clearing)
  );

  epda_decide #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_decide (
    .item       (s1_item),
    .flags      (cur_flags),
    .count      (count),
    .cfg        (cfg),
    .result     (result),
    .count_next (count_next),
    .flag_we    (flag_we),
    .flags_next (flags_next)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.early_threshold        <= CFG_W'(600);
      cfg.low_priority_threshold <= CFG_W'(500);
      cfg.buffer_capacity        <= CFG_W'(1024);
      cfg.active_channels        <= ACT_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_EARLY_THRESHOLD:        cfg.early_threshold        <= cfg_data;
        REG_LOW_PRIORITY_THRESHOLD: cfg.low_priority_threshold <= cfg_data;
        REG_BUFFER_CAPACITY:        cfg.buffer_capacity        <= cfg_data;
        REG_ACTIVE_CHANNELS:        cfg.active_channels        <= cfg_data[ACT_W-1:0];
      endcase
    end
  end

  // Input stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
    if (s_accept) begin
      s1_item <= in_item;
      s1_idx  <= in_idx;
    end
  end

  // Buffer occupancy and the last flag write for forwarding.
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      lw_valid <= 1'b0;
    end else begin
      if (s1_adv) begin
        count <= count_next;
      end
      if (wr_en) begin
        lw_valid <= 1'b1;
      end
    end
    if (wr_en) begin
      lw_idx   <= s1_idx;
      lw_flags <= flags_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (s1_adv) begin
      m_tdata <= M_TDATA_W'({result.occupancy, result.drop_cause, result.accepted});
    end
  end

endmodule

@@ hdl/epda_checker.sv @@
// ----------------------------------------------------------------------------
// epda_checker
// Port-level checks for the admission block, bound to the top level.
// ----------------------------------------------------------------------------
module epda_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [epda_pkg::M_TDATA_W-1:0]    m_tdata
);
  import epda_pkg::*;

  // A result waiting on the output holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // An admitted cell never carries a drop cause.
  a_acc_cause: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[2:1] == CAUSE_NONE)
    else $error("admitted cell reports a drop cause");

  // An admitted cell leaves at least one cell in the buffer.
  a_acc_occ: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[13:3] != '0)
    else $error("admitted cell with empty buffer");

  // The flag sweep after reset holds off input and no result is pending.
  a_reset: assert property (@(posedge clk)
    rst |=> !s_tready && !m_tvalid)
    else $error("block not quiet after reset");

endmodule

bind early_packet_discard_admission epda_checker u_epda_checker (.*);

@@ tb/sv/epda_admission_checker.sv @@
// ----------------------------------------------------------------------------
// epda_admission_checker
// Watches the input, result and register channels of the early packet discard
// admission block. It keeps its own copy of the per-channel frame flags, the
// buffer occupancy and the registers. It predicts one result for every input
// beat taken, and compares each result beat field by field with the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------
module epda_admission_checker #(
  parameter int unsigned NUM_CHANNELS = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [epda_pkg::S_TDATA_W-1:0]   s_tdata,   // [7:0] channel, [8] low_priority
  input  logic                             s_tlast,   // end_of_frame
  input  logic [epda_pkg::S_TUSER_W-1:0]   s_tuser,   // [0] opcode, [1] framed_cell
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [epda_pkg::M_TDATA_W-1:0]   m_tdata,   // [0] accepted, [2:1] drop_cause,
                                                      // [13:3] occupancy
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [epda_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [epda_pkg::CFG_W-1:0]       cfg_data,
  output int                               fail_count,
  output int                               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import epda_pkg::*;

  localparam int unsigned CH_W = $clog2(NUM_CHANNELS);

  // Shadow registers and block state.
  admit_cfg_t        shadow_cfg;
  logic              frame_good [NUM_CHANNELS];
  logic              awaiting_start [NUM_CHANNELS];
  logic [CNT_W-1:0]  buffer_fill;

  // Results predicted and not yet seen on the result channel.
  admit_result_t     expected_results [$];

  cell_item_t        taken_cell;
  admit_result_t     want;
  logic              got_accepted;
  drop_cause_t       got_cause;
  logic [CNT_W-1:0]  got_occupancy;
  int                result_index;

  initial fail_count = 0;
  initial outstanding = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] admission check: %s", $realtime, msg);
    fail_count++;
  endtask

  // Admission decision for one item; updates the shadow state as the block
  // would.
  function automatic admit_result_t predict_admission(input cell_item_t c);
    admit_result_t    r;
    logic [CH_W-1:0]  ch;
    logic [CNT_W-1:0] room;
    r.accepted   = 1'b0;
    r.drop_cause = CAUSE_NONE;
    ch   = CH_W'(c.channel);
    // Programmed capacity is clipped to the physical depth.
    room = (shadow_cfg.buffer_capacity > DEPTH_LIMIT) ? DEPTH_LIMIT
                                                      : shadow_cfg.buffer_capacity;
    if (c.opcode == OP_SERVE) begin
      if (buffer_fill != '0) buffer_fill = buffer_fill - CNT_W'(1);
    end else if (({1'b0, c.channel} >= shadow_cfg.active_channels) ||
                 (32'(c.channel) >= NUM_CHANNELS)) begin
      r.drop_cause = CAUSE_ILLEGAL;
    end else if (!c.framed_cell) begin
      // Plain cells only see the overflow check.
      if (buffer_fill < room) begin
        buffer_fill = buffer_fill + CNT_W'(1);
        r.accepted  = 1'b1;
      end else begin
        r.drop_cause = CAUSE_FULL;
      end
    end else begin
      // The thresholds are only consulted at the first cell of a frame.
      if (awaiting_start[ch]) begin
        awaiting_start[ch] = 1'b0;
        if (buffer_fill >= shadow_cfg.early_threshold) frame_good[ch] = 1'b0;
        if (c.low_priority && buffer_fill >= shadow_cfg.low_priority_threshold)
          frame_good[ch] = 1'b0;
      end
      // The closing cell clears the flags, so it is always offered.
      if (c.end_of_frame) begin
        frame_good[ch]     = 1'b1;
        awaiting_start[ch] = 1'b1;
      end
      if (!frame_good[ch]) begin
        r.drop_cause = CAUSE_FRAME;
      end else if (buffer_fill < room) begin
        buffer_fill = buffer_fill + CNT_W'(1);
        r.accepted  = 1'b1;
      end else begin
        // An overflow poisons the rest of the frame, or the next one when
        // the closing cell is lost.
        frame_good[ch] = 1'b0;
        r.drop_cause   = CAUSE_FULL;
      end
    end
    r.occupancy = buffer_fill;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      // Register values after reset.
      shadow_cfg.early_threshold        = CFG_W'(600);
      shadow_cfg.low_priority_threshold = CFG_W'(500);
      shadow_cfg.buffer_capacity        = CFG_W'(1024);
      shadow_cfg.active_channels        = ACT_W'(256);
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        frame_good[i]     = 1'b1;
        awaiting_start[i] = 1'b1;
      end
      buffer_fill  = '0;
      result_index = 0;
      expected_results.delete();
    end else begin
      // Register writes.
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_EARLY_THRESHOLD:        shadow_cfg.early_threshold = cfg_data;
          REG_LOW_PRIORITY_THRESHOLD: shadow_cfg.low_priority_threshold = cfg_data;
          REG_BUFFER_CAPACITY:        shadow_cfg.buffer_capacity = cfg_data;
          REG_ACTIVE_CHANNELS:        shadow_cfg.active_channels = cfg_data[ACT_W-1:0];
          default: ;
        endcase
      end

      // Result beats against the oldest prediction.
      if (m_tvalid && m_tready) begin
        got_accepted  = m_tdata[0];
        got_cause     = drop_cause_t'(m_tdata[2:1]);
        got_occupancy = m_tdata[13:3];
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result beat %0d arrived with nothing expected",
                                    result_index));
        end else begin
          want = expected_results.pop_front();
          if (got_accepted !== want.accepted)
            report_mismatch($sformatf("beat %0d accepted got %0b, expected %0b",
                                      result_index, got_accepted, want.accepted));
          if (got_cause !== want.drop_cause)
            report_mismatch($sformatf("beat %0d drop_cause got %0d, expected %0d",
                                      result_index, got_cause, want.drop_cause));
          if (got_occupancy !== want.occupancy)
            report_mismatch($sformatf("beat %0d occupancy got %0d, expected %0d",
                                      result_index, got_occupancy, want.occupancy));
        end
        result_index++;
      end

      // Input beats produce one prediction each.
      if (s_tvalid && s_tready) begin
        taken_cell.opcode       = opcode_t'(s_tuser[0]);
        taken_cell.framed_cell  = s_tuser[1];
        taken_cell.channel      = s_tdata[7:0];
        taken_cell.low_priority = s_tdata[8];
        taken_cell.end_of_frame = s_tlast;
        expected_results.push_back(predict_admission(taken_cell));
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

@@ tb/sv/tb_early_packet_discard_admission.sv @@
// ----------------------------------------------------------------------------
// tb_early_packet_discard_admission
// Stimulus for the early packet discard admission block. A short directed run
// covers the frame discard cases. Random phases then follow, each with its own
// register setting: interleaved frames on a small pool of channels, plain
// cells, broken frames, noise and serve requests. Input beats come in bursts
// with gaps, the result side stalls on its own pattern, and twice it holds off
// long enough to back the block up. The checker does the comparing.
// ----------------------------------------------------------------------------
module tb_early_packet_discard_admission;
  timeunit 1ns;
  timeprecision 1ps;
  import epda_pkg::*;

  localparam realtime CLK_PERIOD  = 10ns;
  localparam int      QUIET_LIMIT = 4000;
  localparam int      LONG_STALL  = 200;
  localparam int      POOL_SIZE   = 8;
  localparam int      TAIL_CYCLES = 10;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata   = '0;
  logic                  s_tlast   = 1'b0;
  logic [S_TUSER_W-1:0]  s_tuser   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data  = '0;
  int                    fail_count;
  int                    outstanding;

  // Items waiting to be offered on the input channel.
  cell_item_t            cell_backlog [$];

  // Open frames on the channel pool.
  int                    cells_left [POOL_SIZE];
  bit                    frame_clp  [POOL_SIZE];

  int                    burst_left = 0;
  int                    gap_left   = 0;
  cell_item_t            next_cell;

  int                    stalls_asked = 0;
  int                    stalls_done  = 0;
  int                    stall_left   = 0;
  int                    rx_mode      = 0;
  int                    mode_left    = 0;
  logic                  rx_ready;

  int                    quiet_cycles = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  early_packet_discard_admission uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  epda_admission_checker chk (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (cell_backlog.size() > 0) begin
        next_cell = cell_backlog.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, next_cell.low_priority, next_cell.channel};
        s_tlast  <= next_cell.end_of_frame;
        s_tuser  <= {next_cell.framed_cell, next_cell.opcode};
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(31);
          gap_left   = ($urandom_range(9) < 4) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stretches of differing readiness, plus long hold-offs on request.
  always @(posedge clk) begin
    if (rst) begin
      rx_ready = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rx_ready = 1'b0;
    end else if (stalls_done < stalls_asked) begin
      stalls_done++;
      stall_left = LONG_STALL;
      rx_ready   = 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = $urandom_range(3);
        mode_left = $urandom_range(1, 64);
      end
      mode_left--;
      case (rx_mode)
        0:       rx_ready = 1'b1;
        1:       rx_ready = ($urandom_range(1) == 0);
        2:       rx_ready = ($urandom_range(3) == 0);
        default: rx_ready = ($urandom_range(9) != 0);
      endcase
    end
    m_tready <= rx_ready;
  end

  // Watchdog on cycles in which no channel moves a beat.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_cell(input opcode_t op, input int ch, input bit lp, input bit eof,
                           input bit framed);
    cell_item_t c;
    c.opcode       = op;
    c.channel      = ch[CH_IN_W-1:0];
    c.low_priority = lp;
    c.end_of_frame = eof;
    c.framed_cell  = framed;
    cell_backlog.push_back(c);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Block is idle once every item is offered, taken and answered.
  task automatic wait_drained();
    do @(posedge clk); while (cell_backlog.size() != 0 || s_tvalid || outstanding != 0);
  endtask

  task automatic program_block(input int early, input int lowp, input int cap, input int act);
    write_reg(REG_EARLY_THRESHOLD, CFG_W'(early));
    write_reg(REG_LOW_PRIORITY_THRESHOLD, CFG_W'(lowp));
    write_reg(REG_BUFFER_CAPACITY, CFG_W'(cap));
    write_reg(REG_ACTIVE_CHANNELS, CFG_W'(act));
  endtask

  // Mostly interleaved well-formed frames on the pool, with plain cells,
  // broken frames and noise mixed in.
  task automatic queue_random_cells(input int count, input int serve_pct);
    int ch;
    int pick;
    bit eof;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < serve_pct) begin
        push_cell(OP_SERVE, $urandom_range(255), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
      end else begin
        pick = $urandom_range(99);
        ch   = $urandom_range(POOL_SIZE - 1);
        if (pick < 75) begin
          if (cells_left[ch] == 0) begin
            cells_left[ch] = $urandom_range(1, 6);
            frame_clp[ch]  = 1'($urandom_range(1));
          end
          eof = (cells_left[ch] == 1);
          cells_left[ch]--;
          push_cell(OP_ARRIVAL, ch, frame_clp[ch], eof, 1'b1);
        end else if (pick < 85) begin
          push_cell(OP_ARRIVAL, ch, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0);
        end else if (pick < 95) begin
          // A frame cut short or closed out of turn.
          eof = 1'($urandom_range(1));
          if (eof) cells_left[ch] = 0;
          push_cell(OP_ARRIVAL, ch, 1'($urandom_range(1)), eof, 1'b1);
        end else begin
          push_cell(OP_ARRIVAL, $urandom_range(255), 1'($urandom_range(1)),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
        end
      end
    end
  endtask

  task automatic run_phase(input int early, input int lowp, input int cap, input int act,
                           input int count, input int serve_pct, input bit hold_off);
    wait_drained();
    program_block(early, lowp, cap, act);
    queue_random_cells(count, serve_pct);
    if (hold_off) stalls_asked++;
  endtask

  initial begin
    for (int i = 0; i < POOL_SIZE; i++) begin
      cells_left[i] = 0;
      frame_clp[i]  = 1'b0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: tiny buffer so that every discard path shows within a few cells.
    program_block(3, 2, 4, 200);
    push_cell(OP_SERVE,   255, 1'b1, 1'b1, 1'b1);  // serve on an empty buffer
    push_cell(OP_ARRIVAL, 0,   1'b0, 1'b0, 1'b0);  // plain cell
    push_cell(OP_ARRIVAL, 1,   1'b1, 1'b0, 1'b1);  // low-priority frame, under threshold
    push_cell(OP_ARRIVAL, 2,   1'b1, 1'b0, 1'b1);  // low-priority frame, at threshold
    push_cell(OP_ARRIVAL, 2,   1'b1, 1'b1, 1'b1);  // its closing cell still offered
    push_cell(OP_ARRIVAL, 3,   1'b0, 1'b0, 1'b1);  // frame at the main threshold
    push_cell(OP_ARRIVAL, 1,   1'b1, 1'b0, 1'b1);  // fills the buffer
    push_cell(OP_ARRIVAL, 4,   1'b0, 1'b1, 1'b1);  // closing cell lost to overflow
    push_cell(OP_ARRIVAL, 0,   1'b1, 1'b1, 1'b0);  // plain cell into a full buffer
    push_cell(OP_SERVE,   0,   1'b0, 1'b0, 1'b0);
    push_cell(OP_SERVE,   0,   1'b0, 1'b0, 1'b0);
    push_cell(OP_SERVE,   0,   1'b0, 1'b0, 1'b0);
    push_cell(OP_ARRIVAL, 4,   1'b0, 1'b0, 1'b1);  // next frame on that channel discarded
    push_cell(OP_ARRIVAL, 4,   1'b0, 1'b1, 1'b1);  // and its closing cell accepted
    push_cell(OP_ARRIVAL, 199, 1'b1, 1'b1, 1'b0);  // highest legal channel
    push_cell(OP_ARRIVAL, 200, 1'b0, 1'b0, 1'b0);  // first illegal channel, plain
    push_cell(OP_ARRIVAL, 255, 1'b1, 1'b1, 1'b1);  // illegal channel, framed
    push_cell(OP_ARRIVAL, 3,   1'b0, 1'b1, 1'b1);  // close the discarded frame
    push_cell(OP_ARRIVAL, 1,   1'b1, 1'b1, 1'b1);
    push_cell(OP_SERVE,   128, 1'b0, 1'b1, 1'b0);

    // Random phases, extremes included: zero thresholds, zero capacity,
    // no legal channel, all-ones writes and a capacity above the buffer depth.
    run_phase(12,   8,    16,   256, 100,  45, 1'b1);
    run_phase(0,    0,    20,   6,   80,   40, 1'b0);
    run_phase(2047, 0,    10,   511, 80,   40, 1'b0);
    run_phase(5,    2047, 0,    1,   50,   30, 1'b0);
    run_phase(1,    1,    1,    0,   30,   40, 1'b0);
    run_phase(30,   20,   40,   128, 150,  35, 1'b1);
    run_phase(2047, 2047, 2047, 2047, 280, 2, 1'b0);
    run_phase(600,  500,  1024, 256, 100,  60, 1'b0);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ early_packet_discard_admission.f @@
hdl/epda_pkg.sv
hdl/epda_flag_ram.sv
hdl/epda_decide.sv
hdl/early_packet_discard_admission.sv
hdl/epda_checker.sv
tb/sv/epda_admission_checker.sv
tb/sv/tb_early_packet_discard_admission.sv
